/* src/msc_pkg.sv */
// Shared types and constants for the Mahalanobis skin pixel classifier.
package msc_pkg;

	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 48;

	localparam logic [CfgIdxW-1:0] CFG_MEAN_HUE        = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_MEAN_SATURATION = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_INV_COV_HH      = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_INV_COV_HS      = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_INV_COV_SS      = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_DISTANCE_SQ_LIM = 3'd5;
	localparam logic [CfgIdxW-1:0] CFG_BRIGHTNESS_MIN  = 3'd6;

	localparam logic signed [31:0] INV_COV_UNIT = 32'sd65536;

	localparam logic [7:0] MASK_SKIN = 8'hFF;
	localparam logic [7:0] MASK_NONE = 8'h00;

	typedef struct packed {
		logic [7:0]         mean_hue;
		logic [7:0]         mean_saturation;
		logic signed [31:0] inv_cov_hh;
		logic signed [31:0] inv_cov_hs;
		logic signed [31:0] inv_cov_ss;
		logic [47:0]        distance_sq_limit;
		logic [7:0]         brightness_min;
	} cfg_t;

	// stage 1: squared and cross deltas
	typedef struct packed {
		logic signed [17:0] dh2;
		logic signed [17:0] dhds;
		logic signed [17:0] ds2;
		logic               bright_ok;
	} delta_t;

	// stage 2: weighted terms
	typedef struct packed {
		logic signed [49:0] p_hh;
		logic signed [49:0] p_hs;
		logic signed [49:0] p_ss;
		logic               bright_ok;
	} prod_t;

	// stage 3: squared distance
	typedef struct packed {
		logic signed [51:0] dist_sq;
		logic               bright_ok;
	} dist_t;

endpackage

/* src/msc_if.sv */
// Channel interfaces: pixel in, mask out, configuration writes.
interface msc_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] hue;
	logic [7:0] saturation;
	logic [7:0] brightness;

	modport source (output valid, hue, saturation, brightness, input ready);
	modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

interface msc_mask_if;
	logic       valid;
	logic       ready;
	logic [7:0] mask;

	modport source (output valid, mask, input ready);
	modport sink (input valid, mask, output ready);
endinterface

interface msc_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [msc_pkg::CfgIdxW-1:0]  index;
	logic [msc_pkg::CfgDataW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* src/mahalanobis_skin_pixel_classifier.sv */
// Top level of the Mahalanobis skin pixel classifier.
//
// Usage:
//   pixel  : one HSV pixel per item (hue, saturation, brightness bytes).
//   result : one mask byte per pixel, 255 for skin and 0 otherwise, in input order.
//   cfg    : register writes (index, data); always ready.
//            Write only while no pixel is in flight. Indexes above 6 are dropped.
// Classification: d = (hue - mean_hue, saturation - mean_saturation);
//   skin when d' * M * d (signed Q.16) <= distance_sq_limit and
//   brightness >= brightness_min.
// Timing: four register stages (deltas and squares, coefficient multiply,
//   three-term sum, compare into the output register). A pixel accepted
//   on pixel passes through them in that order and is offered on result.
//   One pixel per clock is sustained while result is taken; each stage holds
//   one item and advances when the next is free.
// Stall: when result is not taken, items pile up stage by stage; pixel.ready
//   drops only when all four stages hold an item. Nothing is lost or repeated.
// Reset: arst_n clears all stage valid bits and loads register defaults
//   (means 0, identity matrix, limit 0, brightness minimum 0).
module mahalanobis_skin_pixel_classifier (
	input  logic              clk,
	input  logic              arst_n,
	msc_pixel_if.sink         pixel,
	msc_mask_if.source        result,
	msc_cfg_if.sink           cfg
);

	msc_pkg::cfg_t   cfg_q;

	logic            v1;
	logic            r2;
	msc_pkg::delta_t d1;
	logic            v2;
	logic            r3;
	msc_pkg::prod_t  d2;
	logic            v3;
	logic            r4;
	msc_pkg::dist_t  d3;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mean_hue          <= 8'd0;
			cfg_q.mean_saturation   <= 8'd0;
			cfg_q.inv_cov_hh        <= msc_pkg::INV_COV_UNIT;
			cfg_q.inv_cov_hs        <= 32'sd0;
			cfg_q.inv_cov_ss        <= msc_pkg::INV_COV_UNIT;
			cfg_q.distance_sq_limit <= 48'd0;
			cfg_q.brightness_min    <= 8'd0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				msc_pkg::CFG_MEAN_HUE: begin
					cfg_q.mean_hue <= cfg.data[7:0];
				end
				msc_pkg::CFG_MEAN_SATURATION: begin
					cfg_q.mean_saturation <= cfg.data[7:0];
				end
				msc_pkg::CFG_INV_COV_HH: begin
					cfg_q.inv_cov_hh <= $signed(cfg.data[31:0]);
				end
				msc_pkg::CFG_INV_COV_HS: begin
					cfg_q.inv_cov_hs <= $signed(cfg.data[31:0]);
				end
				msc_pkg::CFG_INV_COV_SS: begin
					cfg_q.inv_cov_ss <= $signed(cfg.data[31:0]);
				end
				msc_pkg::CFG_DISTANCE_SQ_LIM: begin
					cfg_q.distance_sq_limit <= cfg.data[47:0];
				end
				msc_pkg::CFG_BRIGHTNESS_MIN: begin
					cfg_q.brightness_min <= cfg.data[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	// stage 1: deltas, squares, brightness check
	msc_delta u_delta (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.up_valid   (pixel.valid),
		.up_ready   (pixel.ready),
		.hue        (pixel.hue),
		.saturation (pixel.saturation),
		.brightness (pixel.brightness),
		.dn_valid   (v1),
		.dn_ready   (r2),
		.dn_data    (d1)
	);

	// stage 2: 32x18 signed multiplies against the inverse covariance
	msc_product u_product (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.up_valid (v1),
		.up_ready (r2),
		.up_data  (d1),
		.dn_valid (v2),
		.dn_ready (r3),
		.dn_data  (d2)
	);

	// stage 3: quadratic form sum
	msc_sum u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (v2),
		.up_ready (r3),
		.up_data  (d2),
		.dn_valid (v3),
		.dn_ready (r4),
		.dn_data  (d3)
	);

	// stage 4: threshold and output register
	msc_decide u_decide (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.up_valid (v3),
		.up_ready (r4),
		.up_data  (d3),
		.dn_valid (result.valid),
		.dn_ready (result.ready),
		.mask     (result.mask)
	);

	// the mask is only ever all ones or all zeros
	a_mask_code: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.mask == msc_pkg::MASK_SKIN ||
			result.mask == msc_pkg::MASK_NONE))
		else $error("mask value is neither skin nor background");

	// input backpressure only when every stage is occupied
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel.ready |-> (v1 && v2 && v3 && result.valid && !result.ready))
		else $error("pixel stalled with a free pipeline stage");

	// a stage-1 item blocked by stage 2 stays put
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v1 && !r2) |=> (v1 && $stable(d1)))
		else $error("stage 1 item changed while stalled");

	// a stage-3 item blocked by the output stays put
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v3 && !r4) |=> (v3 && $stable(d3)))
		else $error("stage 3 item changed while stalled");

endmodule

/* src/msc_delta.sv */
// Stage 1: mean-removed hue/saturation, their squares and cross product, brightness check.
module msc_delta (
	input  logic           clk,
	input  logic           arst_n,
	input  msc_pkg::cfg_t  cfg,
	input  logic           up_valid,
	output logic           up_ready,
	input  logic [7:0]     hue,
	input  logic [7:0]     saturation,
	input  logic [7:0]     brightness,
	output logic           dn_valid,
	input  logic           dn_ready,
	output msc_pkg::delta_t dn_data
);

	logic signed [8:0]  dh;
	logic signed [8:0]  ds;
	msc_pkg::delta_t    d_next;
	logic               valid_s1;
	msc_pkg::delta_t    data_s1;

	assign dh = $signed({1'b0, hue}) - $signed({1'b0, cfg.mean_hue});
	assign ds = $signed({1'b0, saturation}) - $signed({1'b0, cfg.mean_saturation});

	always_comb begin
		d_next.dh2       = dh * dh;
		d_next.dhds      = dh * ds;
		d_next.ds2       = ds * ds;
		d_next.bright_ok = (brightness >= cfg.brightness_min);
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s1 <= d_next;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

endmodule

/* src/msc_product.sv */
// Stage 2: weight each delta term by its inverse covariance entry.
module msc_product (
	input  logic            clk,
	input  logic            arst_n,
	input  msc_pkg::cfg_t   cfg,
	input  logic            up_valid,
	output logic            up_ready,
	input  msc_pkg::delta_t up_data,
	output logic            dn_valid,
	input  logic            dn_ready,
	output msc_pkg::prod_t  dn_data
);

	msc_pkg::prod_t p_next;
	logic           valid_s2;
	msc_pkg::prod_t data_s2;

	always_comb begin
		p_next.p_hh      = $signed(cfg.inv_cov_hh) * $signed(up_data.dh2);
		p_next.p_hs      = $signed(cfg.inv_cov_hs) * $signed(up_data.dhds);
		p_next.p_ss      = $signed(cfg.inv_cov_ss) * $signed(up_data.ds2);
		p_next.bright_ok = up_data.bright_ok;
	end

	assign up_ready = !valid_s2 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s2 <= p_next;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_data  = data_s2;

endmodule

/* src/msc_sum.sv */
// Stage 3: add the three weighted terms into the squared distance.
module msc_sum (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_ready,
	input  msc_pkg::prod_t up_data,
	output logic           dn_valid,
	input  logic           dn_ready,
	output msc_pkg::dist_t dn_data
);

	logic signed [51:0] t_hh;
	logic signed [51:0] t_hs2;
	logic signed [51:0] t_ss;
	msc_pkg::dist_t     s_next;
	logic               valid_s3;
	msc_pkg::dist_t     data_s3;

	assign t_hh  = $signed({{2{up_data.p_hh[49]}}, up_data.p_hh});
	// cross term counted twice: shift left by one
	assign t_hs2 = $signed({up_data.p_hs[49], up_data.p_hs, 1'b0});
	assign t_ss  = $signed({{2{up_data.p_ss[49]}}, up_data.p_ss});

	always_comb begin
		s_next.dist_sq   = t_hh + t_hs2 + t_ss;
		s_next.bright_ok = up_data.bright_ok;
	end

	assign up_ready = !valid_s3 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (up_ready) begin
			valid_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s3 <= s_next;
		end
	end

	assign dn_valid = valid_s3;
	assign dn_data  = data_s3;

endmodule

/* src/msc_decide.sv */
// Stage 4: threshold compare and mask output register.
module msc_decide (
	input  logic           clk,
	input  logic           arst_n,
	input  msc_pkg::cfg_t  cfg,
	input  logic           up_valid,
	output logic           up_ready,
	input  msc_pkg::dist_t up_data,
	output logic           dn_valid,
	input  logic           dn_ready,
	output logic [7:0]     mask
);

	logic signed [51:0] limit;
	logic               skin;
	logic               valid_s4;
	logic [7:0]         mask_s4;

	assign limit = $signed({4'b0000, cfg.distance_sq_limit});
	// a negative distance always passes the limit compare
	assign skin  = ($signed(up_data.dist_sq) <= limit) && up_data.bright_ok;

	assign up_ready = !valid_s4 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (up_ready) begin
			valid_s4 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			mask_s4 <= skin ? msc_pkg::MASK_SKIN : msc_pkg::MASK_NONE;
		end
	end

	assign dn_valid = valid_s4;
	assign mask     = mask_s4;

endmodule
